@@ design/dmah_pkg.sv @@
`timescale 1ns / 1ps

package dmah_pkg;

    localparam int BlockW = 128;
    localparam int HalfW  = 64;
    localparam int Rounds = 10;

    typedef logic [7:0]          byte_t;
    typedef logic [BlockW-1:0]   block_t;
    typedef logic [HalfW-1:0]    half_t;

    // AES forward substitution box
    function automatic byte_t sbox(input byte_t x);
        byte_t y;
        unique case (x)
            8'h00: y = 8'h63; 8'h01: y = 8'h7c; 8'h02: y = 8'h77; 8'h03: y = 8'h7b;
            8'h04: y = 8'hf2; 8'h05: y = 8'h6b; 8'h06: y = 8'h6f; 8'h07: y = 8'hc5;
            8'h08: y = 8'h30; 8'h09: y = 8'h01; 8'h0a: y = 8'h67; 8'h0b: y = 8'h2b;
            8'h0c: y = 8'hfe; 8'h0d: y = 8'hd7; 8'h0e: y = 8'hab; 8'h0f: y = 8'h76;
            8'h10: y = 8'hca; 8'h11: y = 8'h82; 8'h12: y = 8'hc9; 8'h13: y = 8'h7d;
            8'h14: y = 8'hfa; 8'h15: y = 8'h59; 8'h16: y = 8'h47; 8'h17: y = 8'hf0;
            8'h18: y = 8'had; 8'h19: y = 8'hd4; 8'h1a: y = 8'ha2; 8'h1b: y = 8'haf;
            8'h1c: y = 8'h9c; 8'h1d: y = 8'ha4; 8'h1e: y = 8'h72; 8'h1f: y = 8'hc0;
            8'h20: y = 8'hb7; 8'h21: y = 8'hfd; 8'h22: y = 8'h93; 8'h23: y = 8'h26;
            8'h24: y = 8'h36; 8'h25: y = 8'h3f; 8'h26: y = 8'hf7; 8'h27: y = 8'hcc;
            8'h28: y = 8'h34; 8'h29: y = 8'ha5; 8'h2a: y = 8'he5; 8'h2b: y = 8'hf1;
            8'h2c: y = 8'h71; 8'h2d: y = 8'hd8; 8'h2e: y = 8'h31; 8'h2f: y = 8'h15;
            8'h30: y = 8'h04; 8'h31: y = 8'hc7; 8'h32: y = 8'h23; 8'h33: y = 8'hc3;
            8'h34: y = 8'h18; 8'h35: y = 8'h96; 8'h36: y = 8'h05; 8'h37: y = 8'h9a;
            8'h38: y = 8'h07; 8'h39: y = 8'h12; 8'h3a: y = 8'h80; 8'h3b: y = 8'he2;
            8'h3c: y = 8'heb; 8'h3d: y = 8'h27; 8'h3e: y = 8'hb2; 8'h3f: y = 8'h75;
            8'h40: y = 8'h09; 8'h41: y = 8'h83; 8'h42: y = 8'h2c; 8'h43: y = 8'h1a;
            8'h44: y = 8'h1b; 8'h45: y = 8'h6e; 8'h46: y = 8'h5a; 8'h47: y = 8'ha0;
            8'h48: y = 8'h52; 8'h49: y = 8'h3b; 8'h4a: y = 8'hd6; 8'h4b: y = 8'hb3;
            8'h4c: y = 8'h29; 8'h4d: y = 8'he3; 8'h4e: y = 8'h2f; 8'h4f: y = 8'h84;
            8'h50: y = 8'h53; 8'h51: y = 8'hd1; 8'h52: y = 8'h00; 8'h53: y = 8'hed;
            8'h54: y = 8'h20; 8'h55: y = 8'hfc; 8'h56: y = 8'hb1; 8'h57: y = 8'h5b;
            8'h58: y = 8'h6a; 8'h59: y = 8'hcb; 8'h5a: y = 8'hbe; 8'h5b: y = 8'h39;
            8'h5c: y = 8'h4a; 8'h5d: y = 8'h4c; 8'h5e: y = 8'h58; 8'h5f: y = 8'hcf;
            8'h60: y = 8'hd0; 8'h61: y = 8'hef; 8'h62: y = 8'haa; 8'h63: y = 8'hfb;
            8'h64: y = 8'h43; 8'h65: y = 8'h4d; 8'h66: y = 8'h33; 8'h67: y = 8'h85;
            8'h68: y = 8'h45; 8'h69: y = 8'hf9; 8'h6a: y = 8'h02; 8'h6b: y = 8'h7f;
            8'h6c: y = 8'h50; 8'h6d: y = 8'h3c; 8'h6e: y = 8'h9f; 8'h6f: y = 8'ha8;
            8'h70: y = 8'h51; 8'h71: y = 8'ha3; 8'h72: y = 8'h40; 8'h73: y = 8'h8f;
            8'h74: y = 8'h92; 8'h75: y = 8'h9d; 8'h76: y = 8'h38; 8'h77: y = 8'hf5;
            8'h78: y = 8'hbc; 8'h79: y = 8'hb6; 8'h7a: y = 8'hda; 8'h7b: y = 8'h21;
            8'h7c: y = 8'h10; 8'h7d: y = 8'hff; 8'h7e: y = 8'hf3; 8'h7f: y = 8'hd2;
            8'h80: y = 8'hcd; 8'h81: y = 8'h0c; 8'h82: y = 8'h13; 8'h83: y = 8'hec;
            8'h84: y = 8'h5f; 8'h85: y = 8'h97; 8'h86: y = 8'h44; 8'h87: y = 8'h17;
            8'h88: y = 8'hc4; 8'h89: y = 8'ha7; 8'h8a: y = 8'h7e; 8'h8b: y = 8'h3d;
            8'h8c: y = 8'h64; 8'h8d: y = 8'h5d; 8'h8e: y = 8'h19; 8'h8f: y = 8'h73;
            8'h90: y = 8'h60; 8'h91: y = 8'h81; 8'h92: y = 8'h4f; 8'h93: y = 8'hdc;
            8'h94: y = 8'h22; 8'h95: y = 8'h2a; 8'h96: y = 8'h90; 8'h97: y = 8'h88;
            8'h98: y = 8'h46; 8'h99: y = 8'hee; 8'h9a: y = 8'hb8; 8'h9b: y = 8'h14;
            8'h9c: y = 8'hde; 8'h9d: y = 8'h5e; 8'h9e: y = 8'h0b; 8'h9f: y = 8'hdb;
            8'ha0: y = 8'he0; 8'ha1: y = 8'h32; 8'ha2: y = 8'h3a; 8'ha3: y = 8'h0a;
            8'ha4: y = 8'h49; 8'ha5: y = 8'h06; 8'ha6: y = 8'h24; 8'ha7: y = 8'h5c;
            8'ha8: y = 8'hc2; 8'ha9: y = 8'hd3; 8'haa: y = 8'hac; 8'hab: y = 8'h62;
            8'hac: y = 8'h91; 8'had: y = 8'h95; 8'hae: y = 8'he4; 8'haf: y = 8'h79;
            8'hb0: y = 8'he7; 8'hb1: y = 8'hc8; 8'hb2: y = 8'h37; 8'hb3: y = 8'h6d;
            8'hb4: y = 8'h8d; 8'hb5: y = 8'hd5; 8'hb6: y = 8'h4e; 8'hb7: y = 8'ha9;
            8'hb8: y = 8'h6c; 8'hb9: y = 8'h56; 8'hba: y = 8'hf4; 8'hbb: y = 8'hea;
            8'hbc: y = 8'h65; 8'hbd: y = 8'h7a; 8'hbe: y = 8'hae; 8'hbf: y = 8'h08;
            8'hc0: y = 8'hba; 8'hc1: y = 8'h78; 8'hc2: y = 8'h25; 8'hc3: y = 8'h2e;
            8'hc4: y = 8'h1c; 8'hc5: y = 8'ha6; 8'hc6: y = 8'hb4; 8'hc7: y = 8'hc6;
            8'hc8: y = 8'he8; 8'hc9: y = 8'hdd; 8'hca: y = 8'h74; 8'hcb: y = 8'h1f;
            8'hcc: y = 8'h4b; 8'hcd: y = 8'hbd; 8'hce: y = 8'h8b; 8'hcf: y = 8'h8a;
            8'hd0: y = 8'h70; 8'hd1: y = 8'h3e; 8'hd2: y = 8'hb5; 8'hd3: y = 8'h66;
            8'hd4: y = 8'h48; 8'hd5: y = 8'h03; 8'hd6: y = 8'hf6; 8'hd7: y = 8'h0e;
            8'hd8: y = 8'h61; 8'hd9: y = 8'h35; 8'hda: y = 8'h57; 8'hdb: y = 8'hb9;
            8'hdc: y = 8'h86; 8'hdd: y = 8'hc1; 8'hde: y = 8'h1d; 8'hdf: y = 8'h9e;
            8'he0: y = 8'he1; 8'he1: y = 8'hf8; 8'he2: y = 8'h98; 8'he3: y = 8'h11;
            8'he4: y = 8'h69; 8'he5: y = 8'hd9; 8'he6: y = 8'h8e; 8'he7: y = 8'h94;
            8'he8: y = 8'h9b; 8'he9: y = 8'h1e; 8'hea: y = 8'h87; 8'heb: y = 8'he9;
            8'hec: y = 8'hce; 8'hed: y = 8'h55; 8'hee: y = 8'h28; 8'hef: y = 8'hdf;
            8'hf0: y = 8'h8c; 8'hf1: y = 8'ha1; 8'hf2: y = 8'h89; 8'hf3: y = 8'h0d;
            8'hf4: y = 8'hbf; 8'hf5: y = 8'he6; 8'hf6: y = 8'h42; 8'hf7: y = 8'h68;
            8'hf8: y = 8'h41; 8'hf9: y = 8'h99; 8'hfa: y = 8'h2d; 8'hfb: y = 8'h0f;
            8'hfc: y = 8'hb0; 8'hfd: y = 8'h54; 8'hfe: y = 8'hbb; 8'hff: y = 8'h16;
            default: y = 8'h00;
        endcase
        return y;
    endfunction

    // round constant for rounds 1..10 (index 0..9)
    function automatic byte_t rcon(input logic [3:0] idx);
        byte_t y;
        unique case (idx)
            4'd0: y = 8'h01;
            4'd1: y = 8'h02;
            4'd2: y = 8'h04;
            4'd3: y = 8'h08;
            4'd4: y = 8'h10;
            4'd5: y = 8'h20;
            4'd6: y = 8'h40;
            4'd7: y = 8'h80;
            4'd8: y = 8'h1b;
            4'd9: y = 8'h36;
            default: y = 8'h00;
        endcase
        return y;
    endfunction

    // multiply by x in GF(2^8)
    function automatic byte_t xtime(input byte_t x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a block, byte 0 in the top bits
    function automatic byte_t get_byte(input block_t b, input int i);
        return b[BlockW-1-8*i -: 8];
    endfunction

endpackage

@@ design/dmah_round.sv @@
`timescale 1ns / 1ps

// One AES-128 encryption round plus the matching key schedule step.
module dmah_round (
    input  dmah_pkg::block_t   state_in,
    input  dmah_pkg::block_t   key_in,
    input  logic [3:0]         round_idx,
    input  logic               last_round,
    output dmah_pkg::block_t   state_out,
    output dmah_pkg::block_t   key_out
);

    dmah_pkg::block_t sub_shift;
    dmah_pkg::block_t mixed;
    logic [31:0]      rot_sub;

    // key schedule: next four words from previous key
    always_comb
    begin
        rot_sub = {dmah_pkg::sbox(key_in[23:16]) ^ dmah_pkg::rcon(round_idx),
                   dmah_pkg::sbox(key_in[15:8]),
                   dmah_pkg::sbox(key_in[7:0]),
                   dmah_pkg::sbox(key_in[31:24])};
        key_out[127:96] = key_in[127:96] ^ rot_sub;
        key_out[95:64]  = key_in[95:64]  ^ key_out[127:96];
        key_out[63:32]  = key_in[63:32]  ^ key_out[95:64];
        key_out[31:0]   = key_in[31:0]   ^ key_out[63:32];
    end

    // SubBytes and ShiftRows, byte index is column * 4 + row
    always_comb
    begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sub_shift[127-8*(c*4+r) -: 8] =
                    dmah_pkg::sbox(dmah_pkg::get_byte(state_in, ((c + r) % 4) * 4 + r));
            end
        end
    end

    // MixColumns
    always_comb
    begin
        for (int c = 0; c < 4; c++) begin
            automatic dmah_pkg::byte_t a0 = dmah_pkg::get_byte(sub_shift, c*4);
            automatic dmah_pkg::byte_t a1 = dmah_pkg::get_byte(sub_shift, c*4+1);
            automatic dmah_pkg::byte_t a2 = dmah_pkg::get_byte(sub_shift, c*4+2);
            automatic dmah_pkg::byte_t a3 = dmah_pkg::get_byte(sub_shift, c*4+3);
            automatic dmah_pkg::byte_t al = a0 ^ a1 ^ a2 ^ a3;
            mixed[127-8*(c*4)   -: 8] = a0 ^ al ^ dmah_pkg::xtime(a0 ^ a1);
            mixed[127-8*(c*4+1) -: 8] = a1 ^ al ^ dmah_pkg::xtime(a1 ^ a2);
            mixed[127-8*(c*4+2) -: 8] = a2 ^ al ^ dmah_pkg::xtime(a2 ^ a3);
            mixed[127-8*(c*4+3) -: 8] = a3 ^ al ^ dmah_pkg::xtime(a3 ^ a0);
        end
    end

    // AddRoundKey
    assign state_out = (last_round ? sub_shift : mixed) ^ key_out;

endmodule

@@ design/dmah_cipher.sv @@
`timescale 1ns / 1ps

// Full AES-128 encryption, ten round units in a chain.
module dmah_cipher (
    input  dmah_pkg::block_t key,
    input  dmah_pkg::block_t plain,
    output dmah_pkg::block_t cipher
);

    dmah_pkg::block_t st [dmah_pkg::Rounds+1];
    dmah_pkg::block_t rk [dmah_pkg::Rounds+1];

    assign st[0] = plain ^ key;
    assign rk[0] = key;

    for (genvar g = 0; g < dmah_pkg::Rounds; g++) begin : g_round
        dmah_round u_round (
            .state_in   (st[g]),
            .key_in     (rk[g]),
            .round_idx  (4'(g)),
            .last_round (g == dmah_pkg::Rounds - 1),
            .state_out  (st[g+1]),
            .key_out    (rk[g+1])
        );
    end

    assign cipher = st[dmah_pkg::Rounds];

endmodule

@@ design/davies_meyer_aes_hash_unit.sv @@
`timescale 1ns / 1ps

// Channel  Handshake                   Payload
// in       in_valid / in_stall         block_high, block_low, start_of_message,
//                                      end_of_message
// out      out_valid / out_stall       hash_high, hash_low, is_final
//
// One item per cycle unless out_stall holds a full result register.
// The whole AES-128 pass plus chaining XOR is one combinational path
// between the input register and the result register.
// Reset clears the chaining value to zero and both valid flags.
// A stalled output holds the input register; in_stall rises only then.
module davies_meyer_aes_hash_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  dmah_pkg::half_t      block_high,
    input  dmah_pkg::half_t      block_low,
    input  logic                 start_of_message,
    input  logic                 end_of_message,
    output logic                 out_valid,
    input  logic                 out_stall,
    output dmah_pkg::half_t      hash_high,
    output dmah_pkg::half_t      hash_low,
    output logic                 is_final
);

    logic              s1_valid_reg;
    dmah_pkg::block_t  s1_block_reg;
    logic              s1_sof_reg;
    logic              s1_eof_reg;
    dmah_pkg::block_t  chain_reg;
    dmah_pkg::block_t  chain_next;
    logic              out_valid_reg;
    dmah_pkg::block_t  hash_reg;
    logic              final_reg;
    dmah_pkg::block_t  plain;
    dmah_pkg::block_t  cipher;
    logic              advance;

    // stage 1 moves on when the result register is empty or not stalled
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;

    // chaining value, cleared at start of message
    assign plain = s1_sof_reg ? '0 : chain_reg;

    dmah_cipher u_cipher (
        .key    (s1_block_reg),
        .plain  (plain),
        .cipher (cipher)
    );

    assign chain_next = cipher ^ plain;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (!in_stall) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall) begin
            s1_block_reg <= {block_high, block_low};
            s1_sof_reg   <= start_of_message;
            s1_eof_reg   <= end_of_message;
        end
    end

    // chaining value and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            chain_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg) begin
                chain_reg <= chain_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg) begin
            hash_reg  <= chain_next;
            final_reg <= s1_eof_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign hash_high = hash_reg[127:64];
    assign hash_low  = hash_reg[63:0];
    assign is_final  = final_reg;

    // checks
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with empty stage");

    a_item_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && advance) |=> out_valid_reg)
        else $error("item lost between stages");

    a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(chain_reg))
        else $error("chaining value changed while output stalled");

    a_chain_matches_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && advance) |=> (hash_reg == chain_reg))
        else $error("result differs from chaining value");

endmodule

@@ test/tb_davies_meyer_aes_hash_unit.sv @@
`timescale 1ns / 1ps

// expected digest for one accepted block
typedef struct {
    dmah_pkg::half_t hi;
    dmah_pkg::half_t lo;
    logic            fin;
} digest_t;

class digest_scoreboard;
    dmah_pkg::half_t chain_hi;
    dmah_pkg::half_t chain_lo;
    digest_t         pending[$];
    int              errors;

    function new();
        chain_hi = '0;
        chain_lo = '0;
        errors   = 0;
    endfunction

    static function logic [7:0] sub_byte(logic [7:0] x);
        logic [7:0] tbl [256];
        tbl = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return tbl[x];
    endfunction

    static function logic [7:0] dbl(logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // AES-128 encrypt; byte 0 sits in the top bits, byte index = col*4 + row
    static function logic [127:0] encrypt(logic [127:0] key, logic [127:0] pt);
        logic [7:0] rk [176];
        logic [7:0] st [16];
        logic [7:0] sh [16];
        logic [7:0] w [4];
        logic [7:0] f, all, rc;
        logic [127:0] ct;
        rc = 8'h01;
        for (int i = 0; i < 16; i++) rk[i] = key[127-8*i -: 8];
        // key schedule
        for (int i = 4; i < 44; i++) begin
            for (int k = 0; k < 4; k++) w[k] = rk[(i-1)*4+k];
            if (i % 4 == 0) begin
                f = w[0];
                w[0] = sub_byte(w[1]) ^ rc;
                w[1] = sub_byte(w[2]);
                w[2] = sub_byte(w[3]);
                w[3] = sub_byte(f);
                rc = dbl(rc);
            end
            for (int k = 0; k < 4; k++) rk[i*4+k] = rk[(i-4)*4+k] ^ w[k];
        end
        for (int i = 0; i < 16; i++) st[i] = pt[127-8*i -: 8] ^ rk[i];
        // ten rounds, last one without column mixing
        for (int r = 1; r <= 10; r++) begin
            for (int c = 0; c < 4; c++)
                for (int j = 0; j < 4; j++)
                    sh[c*4+j] = sub_byte(st[((c+j)%4)*4+j]);
            for (int c = 0; c < 4; c++) begin
                if (r != 10) begin
                    all = sh[c*4] ^ sh[c*4+1] ^ sh[c*4+2] ^ sh[c*4+3];
                    for (int j = 0; j < 4; j++)
                        st[c*4+j] = sh[c*4+j] ^ all ^ dbl(sh[c*4+j] ^ sh[c*4+(j+1)%4]);
                end else begin
                    for (int j = 0; j < 4; j++) st[c*4+j] = sh[c*4+j];
                end
            end
            for (int i = 0; i < 16; i++) st[i] ^= rk[r*16+i];
        end
        for (int i = 0; i < 16; i++) ct[127-8*i -: 8] = st[i];
        return ct;
    endfunction

    // note a block transfer and queue the digest it must produce
    function void note_block(dmah_pkg::half_t bh, dmah_pkg::half_t bl, logic som,
                             logic eom);
        logic [127:0] ct;
        digest_t d;
        if (som) begin
            chain_hi = '0;
            chain_lo = '0;
        end
        ct = encrypt({bh, bl}, {chain_hi, chain_lo});
        chain_hi = ct[127:64] ^ chain_hi;
        chain_lo = ct[63:0] ^ chain_lo;
        d.hi = chain_hi;
        d.lo = chain_lo;
        d.fin = eom;
        pending.push_back(d);
    endfunction

    function void check_digest(dmah_pkg::half_t hh, dmah_pkg::half_t hl, logic fin);
        digest_t d;
        if (pending.size() == 0) begin
            $display("%0t: unexpected digest %h_%h final %b", $time, hh, hl, fin);
            errors++;
            return;
        end
        d = pending.pop_front();
        if (hh !== d.hi) begin
            $display("%0t: hash_high expected %h actual %h", $time, d.hi, hh);
            errors++;
        end
        if (hl !== d.lo) begin
            $display("%0t: hash_low expected %h actual %h", $time, d.lo, hl);
            errors++;
        end
        if (fin !== d.fin) begin
            $display("%0t: is_final expected %b actual %b", $time, d.fin, fin);
            errors++;
        end
    endfunction
endclass

module tb_davies_meyer_aes_hash_unit;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_stall;
    dmah_pkg::half_t block_high = '0;
    dmah_pkg::half_t block_low = '0;
    logic            start_of_message = 1'b0;
    logic            end_of_message = 1'b0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    dmah_pkg::half_t hash_high;
    dmah_pkg::half_t hash_low;
    logic            is_final;

    digest_scoreboard sb;
    bit quiet_phase = 1'b0;
    bit hold_done = 1'b0;
    int blocks_sent = 0;

    davies_meyer_aes_hash_unit DUT (.*);

    always #6 clk = ~clk;

    // send one block, with an optional gap first, and wait for its transfer
    task automatic send_block(dmah_pkg::half_t bh, dmah_pkg::half_t bl, logic som,
                              logic eom);
        if (!quiet_phase && $urandom_range(3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid <= 1'b1;
        block_high <= bh;
        block_low <= bl;
        start_of_message <= som;
        end_of_message <= eom;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_block(bh, bl, som, eom);
        blocks_sent++;
        @(negedge clk);
    endtask

    function automatic dmah_pkg::half_t rand_half();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return dmah_pkg::half_t'(1) << $urandom_range(63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // result side: check every transfer
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_digest(hash_high, hash_low, is_final);

    // receiver stall: one long hold-off, then random bursts
    initial begin
        @(posedge rst_n);
        @(negedge clk);
        while (blocks_sent < 40) @(negedge clk);
        out_stall <= 1'b1;
        repeat (60) @(negedge clk);
        out_stall <= 1'b0;
        hold_done = 1'b1;
        while (!quiet_phase) begin
            if ($urandom_range(3) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(negedge clk);
                out_stall <= 1'b0;
            end
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        out_stall <= 1'b0;
    end

    initial begin
        int len;
        sb = new();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: first block from reset chain, extremes, one-block messages
        send_block('0, '0, 1'b0, 1'b0);
        send_block('0, '0, 1'b0, 1'b1);
        send_block('0, '0, 1'b0, 1'b0);      // carries on after an end block
        send_block('0, '0, 1'b1, 1'b1);
        send_block('1, '1, 1'b1, 1'b1);
        send_block('1, '0, 1'b1, 1'b0);
        send_block('0, '1, 1'b0, 1'b0);
        send_block(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 1'b1, 1'b0);
        send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, 1'b0);
        send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, 1'b1);
        send_block(64'h8000000000000000, 64'h0000000000000001, 1'b1, 1'b1);

        // random messages of 1..8 blocks, occasionally a stray flag
        while (blocks_sent < 1750) begin
            if (blocks_sent > 1550) quiet_phase = 1'b1;
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                logic som, eom;
                som = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
                eom = (i == len - 1) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
                send_block(rand_half(), rand_half(), som, eom);
            end
        end
        in_valid <= 1'b0;
        quiet_phase = 1'b1;

        while (sb.pending.size() != 0 || !hold_done) @(negedge clk);
        repeat (10) @(negedge clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
